>>> rtl/mtcw_pkg.sv
// Package for the multi-task check-in watchdog.
// Holds command and status codes, the sequencer state type and shared constants.
// No dependencies.
`default_nettype none

package mtcw_pkg;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TID_W    = 4;
  localparam int unsigned TICK_W   = 32;
  localparam int unsigned STATUS_W = 2;

  // Timeout that never expires
  localparam logic [TICK_W-1:0] NEVER_EXPIRES = '1;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK    = 2'd0,
    CMD_CHECKIN = 2'd1,
    CMD_CHECK   = 2'd2,
    CMD_LOAD    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_NONE   = 2'd0,
    ST_FEED   = 2'd1,
    ST_FAULT  = 2'd2,
    ST_HALTED = 2'd3
  } status_t;

  typedef enum logic {
    SEQ_IDLE = 1'b0,
    SEQ_SCAN = 1'b1
  } seq_state_t;

endpackage : mtcw_pkg

`default_nettype wire

>>> rtl/mtcw_if.sv
// Handshake channels of the multi-task check-in watchdog: request and response.
// Depends on mtcw_pkg for field widths.
`default_nettype none

interface mtcw_req_if;
  logic                                valid;
  logic                                ready;
  logic [mtcw_pkg::CMD_W-1:0]          cmd;
  logic [mtcw_pkg::TID_W-1:0]          task_id;
  logic [mtcw_pkg::TICK_W-1:0]         timeout_value;

  modport source (output valid, cmd, task_id, timeout_value, input ready);
  modport sink   (input valid, cmd, task_id, timeout_value, output ready);
endinterface : mtcw_req_if

interface mtcw_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [mtcw_pkg::STATUS_W-1:0]       status;
  logic [mtcw_pkg::TID_W-1:0]          failing_task;

  modport source (output valid, status, failing_task, input ready);
  modport sink   (input valid, status, failing_task, output ready);
endinterface : mtcw_rsp_if

`default_nettype wire

>>> rtl/multi_task_checkin_watchdog.sv
// Top level of the multi-task check-in watchdog: sequencer, task tables and
// scan compare. Depends on mtcw_pkg and the channel interfaces in mtcw_if.sv.
`default_nettype none

// Tick, check-in and timeout-load requests need no scan: the response
// is registered at the accepting edge and the next request may be taken in the
// same cycle the response transfers. A check scans the task tables through one
// read port, one task per cycle, with a single subtract-and-compare unit working
// in the cycle after the read; it holds the request channel off from acceptance
// until the scan is over, and the scan ends early at the first late task. A check
// while halted answers at once. Task tables need no clearing pass: per-entry valid
// bits give the reset values until an entry is written.
module multi_task_checkin_watchdog #(
  parameter int unsigned NUM_TASKS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  mtcw_req_if.sink    req,
  mtcw_rsp_if.source  rsp
);

  localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned CNT_W = $clog2(NUM_TASKS + 1);
  localparam int unsigned EXT_W = 7;

  // Control state
  mtcw_pkg::seq_state_t           state, state_next;
  logic [mtcw_pkg::TICK_W-1:0]    tick_count;
  logic                           halted;
  logic [CNT_W-1:0]               rd_cnt;
  logic                           cmp_vld;
  logic [IDX_W-1:0]               cmp_idx;
  logic                           res_valid;
  logic [NUM_TASKS-1:0]           ck_vld;
  logic [NUM_TASKS-1:0]           to_vld;

  // Payload
  mtcw_pkg::status_t              res_status;
  logic [mtcw_pkg::TID_W-1:0]     res_task;
  logic [mtcw_pkg::TICK_W-1:0]    ck_mem [NUM_TASKS];
  logic [mtcw_pkg::TICK_W-1:0]    to_mem [NUM_TASKS];
  logic [mtcw_pkg::TICK_W-1:0]    ck_rd;
  logic [mtcw_pkg::TICK_W-1:0]    to_rd;
  logic                           ck_rd_ok;
  logic                           to_rd_ok;

  // Combinational
  logic                           in_ready;
  logic                           rd_en;
  logic                           accept;
  mtcw_pkg::cmd_t                 cmd;
  logic [EXT_W-1:0]               tid_ext;
  logic                           tid_ok;
  logic [IDX_W-1:0]               wr_addr;
  logic [IDX_W-1:0]               rd_addr;
  logic [mtcw_pkg::TICK_W-1:0]    ck_eff;
  logic [mtcw_pkg::TICK_W-1:0]    to_eff;
  logic [mtcw_pkg::TICK_W-1:0]    elapsed;
  logic                           late;
  logic                           last_cmp;
  logic [EXT_W-1:0]               cmp_idx_ext;

  // Request decode
  assign accept  = req.valid && in_ready;
  assign cmd     = mtcw_pkg::cmd_t'(req.cmd);
  assign tid_ext = EXT_W'(req.task_id);
  assign tid_ok  = tid_ext < EXT_W'(NUM_TASKS);
  assign wr_addr = tid_ext[IDX_W-1:0];
  assign rd_addr = rd_cnt[IDX_W-1:0];

  // Shared compare unit: elapsed ticks against the task timeout
  assign ck_eff      = ck_rd_ok ? ck_rd : '0;
  assign to_eff      = to_rd_ok ? to_rd : mtcw_pkg::NEVER_EXPIRES;
  assign elapsed     = tick_count - ck_eff;
  assign late        = cmp_vld && (to_eff != mtcw_pkg::NEVER_EXPIRES) && (elapsed > to_eff);
  assign last_cmp    = cmp_vld && (cmp_idx == IDX_W'(NUM_TASKS - 1));
  assign cmp_idx_ext = EXT_W'(cmp_idx);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mtcw_pkg::SEQ_IDLE: begin
        if (accept && cmd == mtcw_pkg::CMD_CHECK && !halted) begin
          state_next = mtcw_pkg::SEQ_SCAN;
        end
      end
      mtcw_pkg::SEQ_SCAN: begin
        if (late || last_cmp) begin
          state_next = mtcw_pkg::SEQ_IDLE;
        end
      end
      default: state_next = mtcw_pkg::SEQ_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    unique case (state)
      mtcw_pkg::SEQ_IDLE: in_ready = !res_valid || rsp.ready;
      mtcw_pkg::SEQ_SCAN: rd_en    = rd_cnt < CNT_W'(NUM_TASKS);
      default: begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
      end
    endcase
  end

  assign req.ready        = in_ready;
  assign rsp.valid        = res_valid;
  assign rsp.status       = res_status;
  assign rsp.failing_task = res_task;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mtcw_pkg::SEQ_IDLE;
      tick_count <= '0;
      halted     <= 1'b0;
      rd_cnt     <= '0;
      cmp_vld    <= 1'b0;
      res_valid  <= 1'b0;
      ck_vld     <= '0;
      to_vld     <= '0;
    end else begin
      state   <= state_next;
      cmp_vld <= rd_en;
      if (rd_en) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (rsp.valid && rsp.ready) begin
        res_valid <= 1'b0;
      end
      if (accept) begin
        unique case (cmd)
          mtcw_pkg::CMD_TICK: begin
            tick_count <= tick_count + mtcw_pkg::TICK_W'(1);
            res_valid  <= 1'b1;
          end
          mtcw_pkg::CMD_CHECKIN: begin
            if (tid_ok) ck_vld[wr_addr] <= 1'b1;
            res_valid <= 1'b1;
          end
          mtcw_pkg::CMD_LOAD: begin
            if (tid_ok) to_vld[wr_addr] <= 1'b1;
            res_valid <= 1'b1;
          end
          mtcw_pkg::CMD_CHECK: begin
            rd_cnt    <= '0;
            res_valid <= halted;
          end
          default: res_valid <= 1'b1;
        endcase
      end
      // Scan finish
      if (state == mtcw_pkg::SEQ_SCAN && (late || last_cmp)) begin
        res_valid <= 1'b1;
        if (late) halted <= 1'b1;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      res_task <= '0;
      if (cmd == mtcw_pkg::CMD_CHECK) begin
        res_status <= halted ? mtcw_pkg::ST_HALTED : mtcw_pkg::ST_FEED;
      end else begin
        res_status <= mtcw_pkg::ST_NONE;
      end
    end else if (state == mtcw_pkg::SEQ_SCAN && late) begin
      res_status <= mtcw_pkg::ST_FAULT;
      res_task   <= cmp_idx_ext[mtcw_pkg::TID_W-1:0];
    end
  end

  // Task tables: write on check-in or load
  always_ff @(posedge clk) begin
    if (accept && tid_ok && cmd == mtcw_pkg::CMD_CHECKIN) begin
      ck_mem[wr_addr] <= tick_count;
    end
    if (accept && tid_ok && cmd == mtcw_pkg::CMD_LOAD) begin
      to_mem[wr_addr] <= req.timeout_value;
    end
  end

  // Task tables: registered scan read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ck_rd    <= ck_mem[rd_addr];
      to_rd    <= to_mem[rd_addr];
      ck_rd_ok <= ck_vld[rd_addr];
      to_rd_ok <= to_vld[rd_addr];
      cmp_idx  <= rd_addr;
    end
  end

`ifndef SYNTHESIS
  // A non-check request answers with no-check status on the next cycle
  a_simple_rsp: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd != mtcw_pkg::CMD_CHECK)
      |=> (rsp.valid && rsp.status == mtcw_pkg::ST_NONE && rsp.failing_task == '0))
    else $error("non-check request did not answer with no-check status");

  // A reported fault always goes with a latched halt
  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == mtcw_pkg::ST_FAULT) |-> halted)
    else $error("fault reported without halt");

  // The halt stays latched until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt cleared without reset");

  // Tick request advances the counter by one
  a_tick_inc: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == mtcw_pkg::CMD_TICK)
      |=> (tick_count == $past(tick_count) + mtcw_pkg::TICK_W'(1)))
    else $error("tick counter did not advance by one");

  // No response is pending and no request is taken while a scan runs
  a_scan_empty: assert property (@(posedge clk) disable iff (rst)
    (state == mtcw_pkg::SEQ_SCAN) |-> (!res_valid && !req.ready))
    else $error("response pending or request ready during scan");
`endif

endmodule : multi_task_checkin_watchdog

`default_nettype wire

>>> test/tb_multi_task_checkin_watchdog.sv
// Self-checking testbench for multi_task_checkin_watchdog: a directed table, then random
// keep-alive traffic, then a run-out that forces a fault and the halt.
// Depends on mtcw_pkg and the channel interfaces in rtl/mtcw_if.sv.
`timescale 1ns / 100ps

module tb_multi_task_checkin_watchdog;

  localparam int NUM_TASKS   = 16;
  localparam int LONG_HOLD   = 300;   // cycles the response side holds off once
  localparam int RANDOM_LIVE = 450;   // random items that keep every task alive
  localparam int RANDOM_RUN  = 95;    // random items with no keep-alive, no idling

  typedef struct packed {
    mtcw_pkg::cmd_t                  cmd;
    logic [mtcw_pkg::TID_W-1:0]      task_id;
    logic [mtcw_pkg::TICK_W-1:0]     timeout_value;
  } wd_cmd_t;

  typedef struct packed {
    mtcw_pkg::status_t               status;
    logic [mtcw_pkg::TID_W-1:0]      failing_task;
  } wd_answer_t;

  typedef struct packed {
    wd_cmd_t    item;
    bit         typed;
    wd_answer_t ans;
  } dir_row_t;

  logic clk;
  logic rst;

  mtcw_req_if req_ch ();
  mtcw_rsp_if rsp_ch ();

  multi_task_checkin_watchdog #(.NUM_TASKS(NUM_TASKS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Watchdog state as the predictor sees it
  logic [mtcw_pkg::TICK_W-1:0] wd_tick;
  logic [mtcw_pkg::TICK_W-1:0] wd_checkin [NUM_TASKS];
  logic [mtcw_pkg::TICK_W-1:0] wd_timeout [NUM_TASKS];
  bit                          wd_halted;

  wd_answer_t pending_answers [$];
  bit         idle_on;
  bit         hold_req;
  int         n_sent;
  int         n_answers;
  int         n_feed;
  int         n_fault;
  int         n_halted;
  int         n_errors;

  // Directed table: answers typed in only where obvious, the rest go to the predictor
  dir_row_t dir_rows [0:18] = '{
    '{'{mtcw_pkg::CMD_CHECK,   4'd0,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_FEED, 4'd0}},
    '{'{mtcw_pkg::CMD_TICK,    4'd15, 32'hFFFF_FFFF}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECKIN, 4'd0,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECKIN, 4'd15, 32'hFFFF_FFFF}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd0,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECK,   4'd0,  32'h0000_0000}, 1'b0, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd15, mtcw_pkg::NEVER_EXPIRES}, 1'b1,
      '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_TICK,    4'd10, 32'h5555_5555}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECKIN, 4'd0,  32'hAAAA_AAAA}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd5,  32'h8000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd10, 32'h7FFF_FFFF}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd3,  32'hFFFF_FFFE}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECK,   4'd9,  32'hFFFF_FFFF}, 1'b0, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd0,  mtcw_pkg::NEVER_EXPIRES}, 1'b1,
      '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECKIN, 4'd6,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_LOAD,    4'd6,  32'h0000_0001}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_TICK,    4'd0,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECK,   4'd0,  32'h0000_0000}, 1'b0, '{mtcw_pkg::ST_NONE, 4'd0}},
    '{'{mtcw_pkg::CMD_CHECKIN, 4'd6,  32'h0000_0000}, 1'b1, '{mtcw_pkg::ST_NONE, 4'd0}}
  };

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Index of the first task past its timeout, or -1 when all are in time
  function automatic int first_late_task();
    logic [mtcw_pkg::TICK_W-1:0] elapsed;
    for (int k = 0; k < NUM_TASKS; k++) begin
      elapsed = wd_tick - wd_checkin[k];
      if (wd_timeout[k] != mtcw_pkg::NEVER_EXPIRES && elapsed > wd_timeout[k]) return k;
    end
    return -1;
  endfunction

  // Apply one command to the watchdog state and return its answer
  function automatic wd_answer_t watchdog_apply(input wd_cmd_t c);
    wd_answer_t ans;
    int         late;
    ans = '{mtcw_pkg::ST_NONE, '0};
    case (c.cmd)
      mtcw_pkg::CMD_TICK: wd_tick = wd_tick + 1;
      mtcw_pkg::CMD_CHECKIN: begin
        if (int'(c.task_id) < NUM_TASKS) wd_checkin[c.task_id] = wd_tick;
      end
      mtcw_pkg::CMD_LOAD: begin
        if (int'(c.task_id) < NUM_TASKS) wd_timeout[c.task_id] = c.timeout_value;
      end
      default: begin
        if (wd_halted) begin
          ans.status = mtcw_pkg::ST_HALTED;
        end else begin
          late = first_late_task();
          if (late < 0) begin
            ans.status = mtcw_pkg::ST_FEED;
          end else begin
            ans.status       = mtcw_pkg::ST_FAULT;
            ans.failing_task = late[mtcw_pkg::TID_W-1:0];
            wd_halted        = 1'b1;
          end
        end
      end
    endcase
    return ans;
  endfunction

  // Random command; with keep_alive a check that would fault turns into a check-in
  function automatic wd_cmd_t random_command(input bit keep_alive);
    wd_cmd_t c;
    int      r;
    int      late;
    r = $urandom_range(0, 19);
    c.cmd = (r < 7)  ? mtcw_pkg::CMD_TICK :
            (r < 12) ? mtcw_pkg::CMD_CHECKIN :
            (r < 16) ? mtcw_pkg::CMD_CHECK : mtcw_pkg::CMD_LOAD;
    r = $urandom_range(0, 15);
    c.task_id = r[mtcw_pkg::TID_W-1:0];
    r = $urandom_range(0, 9);
    if (c.cmd != mtcw_pkg::CMD_LOAD)
      c.timeout_value = $urandom;
    else if (r < 2)
      c.timeout_value = mtcw_pkg::NEVER_EXPIRES;
    else if (r < 4)
      c.timeout_value = $urandom;
    else
      c.timeout_value = $urandom_range(0, 24);
    if (keep_alive && c.cmd == mtcw_pkg::CMD_CHECK) begin
      late = first_late_task();
      if (late >= 0) begin
        c.cmd     = mtcw_pkg::CMD_CHECKIN;
        c.task_id = late[mtcw_pkg::TID_W-1:0];
      end
    end
    return c;
  endfunction

  // Offer one command, predict its answer at the transfer, maybe idle after it
  task automatic issue_command(input wd_cmd_t c, input bit typed, input wd_answer_t typed_ans);
    wd_answer_t ans;
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= c.cmd;
    req_ch.task_id       <= c.task_id;
    req_ch.timeout_value <= c.timeout_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    ans = watchdog_apply(c);
    pending_answers.push_back(typed ? typed_ans : ans);
    n_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Response side: random stalls, one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare each response transfer with the oldest expected answer
  always @(posedge clk) begin
    wd_answer_t exp_ans;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_answers++;
      case (rsp_ch.status)
        mtcw_pkg::ST_FEED:   n_feed++;
        mtcw_pkg::ST_FAULT:  n_fault++;
        mtcw_pkg::ST_HALTED: n_halted++;
        default:   ;
      endcase
      if (pending_answers.size() == 0) begin
        $error("unexpected response: status %0d failing_task %0d",
               rsp_ch.status, rsp_ch.failing_task);
        n_errors++;
      end else begin
        exp_ans = pending_answers.pop_front();
        if (rsp_ch.status !== exp_ans.status) begin
          $error("status: expected %0d, got %0d", exp_ans.status, rsp_ch.status);
          n_errors++;
        end
        if (rsp_ch.failing_task !== exp_ans.failing_task) begin
          $error("failing_task: expected %0d, got %0d",
                 exp_ans.failing_task, rsp_ch.failing_task);
          n_errors++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    wd_cmd_t c;
    int      fault_tid;
    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.cmd           <= mtcw_pkg::CMD_TICK;
    req_ch.task_id       <= '0;
    req_ch.timeout_value <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    wd_tick   = '0;
    wd_halted = 1'b0;
    for (int k = 0; k < NUM_TASKS; k++) begin
      wd_checkin[k] = '0;
      wd_timeout[k] = mtcw_pkg::NEVER_EXPIRES;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (dir_rows[i]) issue_command(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].ans);

    // Keep-alive traffic: every check should feed
    for (int i = 0; i < RANDOM_LIVE; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (i == 200) hold_req = 1'b1;
      c = random_command(1'b1);
      issue_command(c, 1'b0, '0);
    end

    // Run-out without keep-alive or idling, then force a late task and check the halt
    idle_on = 1'b0;
    for (int i = 0; i < RANDOM_RUN; i++) begin
      c = random_command(1'b0);
      issue_command(c, 1'b0, '0);
    end
    fault_tid = $urandom_range(0, NUM_TASKS - 1);
    issue_command('{mtcw_pkg::CMD_LOAD, fault_tid[mtcw_pkg::TID_W-1:0], 32'd0}, 1'b0, '0);
    issue_command('{mtcw_pkg::CMD_TICK, 4'd0, 32'd0}, 1'b0, '0);
    issue_command('{mtcw_pkg::CMD_CHECK, 4'd0, 32'd0}, 1'b0, '0);
    issue_command('{mtcw_pkg::CMD_CHECKIN, fault_tid[mtcw_pkg::TID_W-1:0], 32'd0}, 1'b0, '0);
    issue_command('{mtcw_pkg::CMD_CHECK, 4'd0, 32'd0}, 1'b0, '0);
    req_ch.valid <= 1'b0;

    // Drain, then allow a full scan worth of cycles for stray responses
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (NUM_TASKS + 8) @(posedge clk);

    $display("Sent %0d commands, checked %0d responses: %0d feeds, %0d faults, %0d halted.",
             n_sent, n_answers, n_feed, n_fault, n_halted);
    $display("Mismatches: %0d, answers left over: %0d.", n_errors, pending_answers.size());
    if (n_errors == 0 && pending_answers.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on the testbench itself
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule : tb_multi_task_checkin_watchdog
